// File: rtl/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int INDEX_W          = 16;
  localparam int LEN_W            = 17;
  localparam int POS_W            = LEN_W + 1;
  localparam int PHASE_W          = 32;
  localparam int MAX_TRACE_LENGTH = 65536;
  localparam int CORDIC_STAGES    = 28;
  localparam int SHIFT_W          = $clog2(CORDIC_STAGES);
  localparam int GUARD_BITS       = 4;
  // sample plus guard bits, one bit for the quarter-turn negation, two for cordic growth
  localparam int CW               = SAMPLE_W + GUARD_BITS + 3;
  localparam int KGAIN_FRAC       = 25;
  localparam int KGAIN_W          = KGAIN_FRAC + 1;
  localparam int KGAIN            = 20376027;
  localparam int PROD_W           = CW + KGAIN_W;
  localparam int ROUND_SHIFT      = KGAIN_FRAC + GUARD_BITS;

  // configuration register indexes
  localparam int CFG_INDEX_W      = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACE_LENGTH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_PHASE   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 8'd3;

  localparam logic [LEN_W-1:0] TRACE_LENGTH_RESET = 17'd1024;

  typedef struct packed {
    logic                      enable;
    logic [LEN_W-1:0]          trace_length;
    logic [PHASE_W-1:0]        zero_phase;
    logic signed [PHASE_W-1:0] phase_step;
  } cfg_t;

  // one slot of the rotation chain
  typedef struct packed {
    logic                       valid;
    logic                       bypass;
    logic                       bad;
    logic signed [CW-1:0]       x;
    logic signed [CW-1:0]       y;
    logic signed [PHASE_W-1:0]  z;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cell_t;

  // arctan(2^-i) in 2^-32 turn units
  function automatic logic [PHASE_W-1:0] cordic_angle(input int unsigned i);
    logic [PHASE_W-1:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/complex_phase_correction_core.sv
// zero- and first-order phase correction of a complex sample stream. each sample is
// rotated by zero_phase + phase_step * s (2^-32 turn units, wrapping), where s is the
// signed position: the sample index for the first half of the trace, index minus
// trace_length for the second half. rotation is an exact quarter-turn step followed by
// a 28-cell cordic chain and a gain-compensation multiply; results round to nearest
// and saturate to 24 bits. an index at or above trace_length (clamped to 65536) passes
// the sample unchanged with the error flag in tuser; with enable low every sample
// passes unchanged. one sample is taken every clock while the output buffer has room;
// the path from input transaction to output valid runs through three front stages
// (position, phase multiply, quadrant), one register per cordic cell, one gain multiply
// and the output register. a two-entry output buffer lets the next input transaction in
// while a result waits; the chain stalls only once both entries are full. configuration
// writes are always ready and should be issued only while no samples are in flight.
`default_nettype none

module complex_phase_correction_core (
  input  wire         clk,
  input  wire         rst,
  // sample input: in_real [23:0], in_imag [47:24], sample_index [63:48]
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,
  // result output: out_real [23:0], out_imag [47:24]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,
  // result flags: index_error [0]
  output logic [0:0]  m_tuser,
  // register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import cpc_pkg::*;

  cfg_t  cfg;
  cell_t chain [CORDIC_STAGES+1];
  logic  advance;
  logic signed [SAMPLE_W-1:0] o_re, o_im;
  logic  o_err;

  // register file, writes accepted every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.trace_length <= TRACE_LENGTH_RESET;
      cfg.zero_phase   <= '0;
      cfg.phase_step   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_TRACE_LENGTH: cfg.trace_length <= cfg_data[LEN_W-1:0];
        REG_ZERO_PHASE:   cfg.zero_phase   <= cfg_data;
        REG_PHASE_STEP:   cfg.phase_step   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // the whole chain moves together whenever the output buffer has room
  assign s_tready = advance;

  cpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_tvalid),
    .in_real  ($signed(s_tdata[SAMPLE_W-1:0])),
    .in_imag  ($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W])),
    .in_index (s_tdata[2*SAMPLE_W+INDEX_W-1:2*SAMPLE_W]),
    .cfg      (cfg),
    .d_out    (chain[0])
  );

  // cordic cells, cell g shifts by g and uses arctan(2^-g)
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    cpc_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .shift   (SHIFT_W'(g)),
      .angle   (cordic_angle(g)),
      .d_in    (chain[g]),
      .d_out   (chain[g+1])
    );
  end

  cpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .d_in      (chain[CORDIC_STAGES]),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_real  (o_re),
    .out_imag  (o_im),
    .out_error (o_err)
  );

  assign m_tdata = {o_im, o_re};
  assign m_tuser = o_err;

endmodule

`default_nettype wire

// File: rtl/cpc_front.sv
`default_nettype none

module cpc_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 advance,
  input  wire                                 in_valid,
  input  wire logic signed [cpc_pkg::SAMPLE_W-1:0] in_real,
  input  wire logic signed [cpc_pkg::SAMPLE_W-1:0] in_imag,
  input  wire logic [cpc_pkg::INDEX_W-1:0]    in_index,
  input  wire cpc_pkg::cfg_t                  cfg,
  output cpc_pkg::cell_t                      d_out
);
  import cpc_pkg::*;

  // stage 0: signed position and range check
  logic                       v0, byp0, bad0;
  logic signed [SAMPLE_W-1:0] re0, im0;
  logic signed [POS_W-1:0]    s0;
  // stage 1: first-order phase offset
  logic                       v1, byp1, bad1;
  logic signed [SAMPLE_W-1:0] re1, im1;
  logic [PHASE_W-1:0]         off1;

  logic [LEN_W-1:0]          len_c, half;
  logic [LEN_W-1:0]          kk;
  logic                      bad_c;
  logic signed [POS_W-1:0]   s_c;
  logic signed [PHASE_W+POS_W-1:0] prod_c;
  logic [PHASE_W-1:0]        phase_c, u_c;
  logic signed [PHASE_W-1:0] z_c;
  logic signed [CW-1:0]      re_e, im_e, x_c, y_c;

  always_comb begin
    if (int'(cfg.trace_length) > MAX_TRACE_LENGTH) begin
      len_c = LEN_W'(MAX_TRACE_LENGTH);
    end else begin
      len_c = cfg.trace_length;
    end
    half  = len_c >> 1;
    kk    = {{(LEN_W-INDEX_W){1'b0}}, in_index};
    bad_c = (kk >= len_c);
    if (kk < half) begin
      s_c = $signed({1'b0, kk});
    end else begin
      s_c = $signed({1'b0, kk}) - $signed({1'b0, len_c});
    end
  end

  assign prod_c = cfg.phase_step * s0;

  always_comb begin
    phase_c = cfg.zero_phase + off1;
    u_c     = phase_c + 32'h2000_0000;
    z_c     = $signed({2'b00, u_c[PHASE_W-3:0]}) - 32'sh2000_0000;
    re_e    = CW'(re1);
    im_e    = CW'(im1);
    case (u_c[PHASE_W-1:PHASE_W-2])
      2'd1: begin
        x_c = -im_e;
        y_c = re_e;
      end
      2'd2: begin
        x_c = -re_e;
        y_c = -im_e;
      end
      2'd3: begin
        x_c = im_e;
        y_c = -re_e;
      end
      default: begin
        x_c = re_e;
        y_c = im_e;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      d_out.valid <= 1'b0;
    end else if (advance) begin
      v0          <= in_valid;
      v1          <= v0;
      d_out.valid <= v1;
    end
    if (advance) begin
      byp0 <= ~cfg.enable | bad_c;
      bad0 <= bad_c;
      re0  <= in_real;
      im0  <= in_imag;
      s0   <= s_c;

      byp1 <= byp0;
      bad1 <= bad0;
      re1  <= re0;
      im1  <= im0;
      off1 <= prod_c[PHASE_W-1:0];

      d_out.bypass <= byp1;
      d_out.bad    <= bad1;
      d_out.re     <= re1;
      d_out.im     <= im1;
      d_out.x      <= x_c <<< GUARD_BITS;
      d_out.y      <= y_c <<< GUARD_BITS;
      d_out.z      <= z_c;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpc_cordic_cell.sv
`default_nettype none

module cpc_cordic_cell (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                advance,
  input  wire logic [cpc_pkg::SHIFT_W-1:0]   shift,
  input  wire logic [cpc_pkg::PHASE_W-1:0]   angle,
  input  wire cpc_pkg::cell_t                d_in,
  output cpc_pkg::cell_t                     d_out
);
  import cpc_pkg::*;

  logic signed [CW-1:0]      xi, yi, dx, dy;
  logic signed [PHASE_W-1:0] zi;

  always_comb begin
    xi = d_in.x;
    yi = d_in.y;
    zi = d_in.z;
    dx = yi >>> shift;
    dy = xi >>> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (advance) begin
      d_out.valid <= d_in.valid;
    end
    if (advance) begin
      d_out.bypass <= d_in.bypass;
      d_out.bad    <= d_in.bad;
      d_out.re     <= d_in.re;
      d_out.im     <= d_in.im;
      // rotate toward zero residual angle
      if (zi >= 0) begin
        d_out.x <= xi - dx;
        d_out.y <= yi + dy;
        d_out.z <= zi - $signed(angle);
      end else begin
        d_out.x <= xi + dx;
        d_out.y <= yi - dy;
        d_out.z <= zi + $signed(angle);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpc_back.sv
`default_nettype none

module cpc_back (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire cpc_pkg::cell_t                   d_in,
  output logic                                  advance,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [cpc_pkg::SAMPLE_W-1:0]   out_real,
  output logic signed [cpc_pkg::SAMPLE_W-1:0]   out_imag,
  output logic                                  out_error
);
  import cpc_pkg::*;

  localparam logic signed [PROD_W-1:0] SAT_MAX = (PROD_W'(1) <<< (SAMPLE_W-1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (ROUND_SHIFT-1);
  localparam logic signed [KGAIN_W-1:0] GAIN = KGAIN_W'(KGAIN);

  // gain stage
  logic                       g_v, g_byp, g_bad;
  logic signed [SAMPLE_W-1:0] g_re, g_im;
  logic signed [PROD_W-1:0]   g_px, g_py;

  // skid slot
  logic                       sk_v, sk_err;
  logic signed [SAMPLE_W-1:0] sk_re, sk_im;

  logic signed [PROD_W-1:0]   rx, ry;
  logic signed [SAMPLE_W-1:0] c_re, c_im;

  function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [PROD_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    rx = (g_px + HALF_LSB) >>> ROUND_SHIFT;
    ry = (g_py + HALF_LSB) >>> ROUND_SHIFT;
    if (g_byp) begin
      c_re = g_re;
      c_im = g_im;
    end else begin
      c_re = sat(rx);
      c_im = sat(ry);
    end
  end

  assign advance = ~sk_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v       <= 1'b0;
      sk_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        g_v <= d_in.valid;
        if (!out_valid || out_ready) begin
          out_valid <= g_v;
        end else if (g_v) begin
          sk_v <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b1;
        sk_v      <= 1'b0;
      end
    end
    if (advance) begin
      g_byp <= d_in.bypass;
      g_bad <= d_in.bad;
      g_re  <= d_in.re;
      g_im  <= d_in.im;
      g_px  <= d_in.x * GAIN;
      g_py  <= d_in.y * GAIN;
      if (!out_valid || out_ready) begin
        out_real  <= c_re;
        out_imag  <= c_im;
        out_error <= g_bad;
      end else begin
        sk_re  <= c_re;
        sk_im  <= c_im;
        sk_err <= g_bad;
      end
    end else if (out_ready) begin
      out_real  <= sk_re;
      out_imag  <= sk_im;
      out_error <= sk_err;
    end
  end

endmodule

`default_nettype wire
